// File: rtl/haa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the host address allocator.
// No dependencies; every other file of the block imports this package.

package haa_pkg;

	// Pool geometry (supported range of HOST_BITS: 2 to 8, bounded by the fixed port widths)
	localparam int HOST_BITS = 8;
	localparam int POOL_SIZE = 1 << HOST_BITS;
	localparam int NODE_W    = HOST_BITS;
	localparam int CNT_W     = HOST_BITS + 1;
	localparam int LVL_W     = $clog2(HOST_BITS);
	localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(HOST_BITS - 1);

	// Fixed field widths of the word ports
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Operation codes
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Tree memory read address select
	localparam int RDSEL_W = 3;
	localparam logic [RDSEL_W-1:0] RD_DESC_ROOT = 3'd0;
	localparam logic [RDSEL_W-1:0] RD_DESC_NEXT = 3'd1;
	localparam logic [RDSEL_W-1:0] RD_DESC_CUR  = 3'd2;
	localparam logic [RDSEL_W-1:0] RD_UP_CUR    = 3'd3;
	localparam logic [RDSEL_W-1:0] RD_UP_NEXT   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] host_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   granted_address;
		logic [COUNT_W-1:0]  used_count;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic                accept;
		logic                clr_en;
		logic                rd_en;
		logic [RDSEL_W-1:0]  rd_sel;
		logic                desc_step;
		logic                desc_last;
		logic                up_write;
		logic                first_level;
		logic                leaf_val;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                load_out;
		logic [STATUS_W-1:0] res_status;
		logic                grant;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic            clr_last;
		logic            root_full;
		logic            leaf_used;
		logic [OP_W-1:0] op;
	} sts_t;

endpackage

// File: rtl/haa_datapath.sv
`timescale 1ns / 1ps
// Datapath of the host address allocator: tree memory, walk registers,
// used counter and result register. Depends on haa_pkg.

module haa_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  haa_pkg::req_t req,
	input  haa_pkg::cmd_t cmd,
	output haa_pkg::sts_t sts,
	output haa_pkg::rsp_t rsp
);
	import haa_pkg::*;

	// Parent of leaf 0 holds the network bit in its left slot
	localparam logic [NODE_W-1:0] LEAF0_PARENT = {1'b1, {(NODE_W-1){1'b0}}};
	localparam logic [NODE_W-1:0] ROOT_NODE    = NODE_W'(1);

	// Entry n holds {right child full, left child full} of heap node n
	logic [1:0]        tree_mem [POOL_SIZE];
	logic [1:0]        rd_q;

	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] desc_node_q;
	logic [NODE_W-1:0] up_node_q;
	logic [NODE_W-1:0] addr_q;
	logic [NODE_W-1:0] path_q;
	logic [OP_W-1:0]   op_q;
	logic              child_q;
	logic              root_full_q;
	logic [CNT_W-1:0]  cnt_q;
	rsp_t              rsp_q;

	logic [NODE_W-1:0] req_addr;
	logic [NODE_W-1:0] desc_next;
	logic [NODE_W-1:0] rd_addr;
	logic [NODE_W-1:0] wr_addr;
	logic              up_child;
	logic              wr_en;
	logic [1:0]        up_word;
	logic [1:0]        clr_word;
	logic [1:0]        wr_data;

	assign req_addr = NODE_W'(req.host_address);

	// Descent: go right only when the left subtree is full
	assign desc_next = {desc_node_q[NODE_W-2:0], rd_q[0]};

	// Ascent: replace the slot of the child we came from
	assign up_child = cmd.first_level ? cmd.leaf_val : child_q;
	always_comb begin
		up_word            = rd_q;
		up_word[path_q[0]] = up_child;
	end

	// Reset image: only network and broadcast leaves used
	assign clr_word = {clr_q == '1, clr_q == LEAF0_PARENT};

	always_comb begin
		case (cmd.rd_sel)
			RD_DESC_ROOT: rd_addr = ROOT_NODE;
			RD_DESC_NEXT: rd_addr = desc_next;
			RD_DESC_CUR:  rd_addr = desc_node_q;
			RD_UP_CUR:    rd_addr = up_node_q;
			RD_UP_NEXT:   rd_addr = up_node_q >> 1;
			default:      rd_addr = ROOT_NODE;
		endcase
	end

	assign wr_en   = cmd.clr_en | cmd.up_write;
	assign wr_addr = cmd.clr_en ? clr_q : up_node_q;
	assign wr_data = cmd.clr_en ? clr_word : up_word;

	// Tree memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= tree_mem[rd_addr];
		end
	end

	// Clear sweep, root mark and used counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			root_full_q <= 1'b0;
			cnt_q       <= CNT_W'(2);
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (wr_en && wr_addr == ROOT_NODE) begin
				root_full_q <= &wr_data;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q        <= req.operation;
			addr_q      <= req_addr;
			path_q      <= req_addr;
			up_node_q   <= {1'b1, req_addr[NODE_W-1:1]};
			desc_node_q <= ROOT_NODE;
		end else if (cmd.desc_step) begin
			desc_node_q <= desc_next;
			if (cmd.desc_last) begin
				addr_q    <= desc_next;
				path_q    <= desc_next;
				up_node_q <= desc_node_q;
			end
		end else if (cmd.up_write) begin
			child_q   <= &up_word;
			up_node_q <= up_node_q >> 1;
			path_q    <= path_q >> 1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status          <= cmd.res_status;
			rsp_q.granted_address <= cmd.grant ? ADDR_W'(addr_q) : '0;
			rsp_q.used_count      <= COUNT_W'(cnt_q);
		end
	end

	assign rsp = rsp_q;

	assign sts.clr_last  = &clr_q;
	assign sts.root_full = root_full_q;
	assign sts.leaf_used = rd_q[path_q[0]];
	assign sts.op        = op_q;

endmodule

// File: rtl/haa_ctrl.sv
`timescale 1ns / 1ps
// Controller of the host address allocator: clear sweep, descent and ascent
// sequencing, handshakes. Depends on haa_pkg.

module haa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  haa_pkg::sts_t sts,
	output haa_pkg::cmd_t cmd
);
	import haa_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_DOWN     = 3'd3;
	localparam logic [2:0] S_UP       = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [LVL_W-1:0]    lvl_q, lvl_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                grant_q, grant_d;
	logic                rsp_valid_q;
	logic                first;

	assign first = (lvl_q == '0);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		lvl_d        = lvl_q;
		res_status_d = res_status_q;
		grant_d      = grant_q;
		cmd          = '0;
		cmd.rd_sel   = RD_DESC_ROOT;
		cmd.res_status = res_status_q;
		cmd.grant    = grant_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				lvl_d = '0;
				case (sts.op)
					OP_REQUEST, OP_RELEASE: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_UP_CUR;
						state_d    = S_UP;
					end
					OP_ALLOC: begin
						if (sts.root_full) begin
							res_status_d = ST_FULL;
							grant_d      = 1'b0;
							state_d      = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_DESC_ROOT;
							state_d    = S_DOWN;
						end
					end
					default: begin
						// unused code: no change, report current count
						res_status_d = ST_OK;
						grant_d      = 1'b0;
						state_d      = S_DONE;
					end
				endcase
			end
			S_DOWN: begin
				cmd.desc_step = 1'b1;
				cmd.rd_en     = 1'b1;
				if (lvl_q == LVL_LAST) begin
					// reread the leaf's parent to start the ascent
					cmd.desc_last = 1'b1;
					cmd.rd_sel    = RD_DESC_CUR;
					lvl_d         = '0;
					state_d       = S_UP;
				end else begin
					cmd.rd_sel = RD_DESC_NEXT;
					lvl_d      = lvl_q + 1'b1;
				end
			end
			S_UP: begin
				if (first && sts.op == OP_REQUEST && sts.leaf_used) begin
					res_status_d = ST_TAKEN;
					grant_d      = 1'b0;
					state_d      = S_DONE;
				end else begin
					cmd.up_write    = 1'b1;
					cmd.first_level = first;
					cmd.leaf_val    = (sts.op != OP_RELEASE);
					cmd.cnt_inc     = first && (sts.op != OP_RELEASE);
					cmd.cnt_dec     = first && (sts.op == OP_RELEASE) && sts.leaf_used;
					if (lvl_q == LVL_LAST) begin
						res_status_d = ST_OK;
						grant_d      = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_UP_NEXT;
						lvl_d      = lvl_q + 1'b1;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			lvl_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Outcome of the current word
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		grant_q      <= grant_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/host_address_allocator.sv
`timescale 1ns / 1ps
// Top level of the host address allocator: controller plus datapath.
// Depends on haa_pkg, haa_ctrl and haa_datapath.

// Hands out host offsets from a pool of 2^HOST_BITS (256). Offsets 0 and 255
// start out used. After reset the block sweeps its tree memory and takes no
// word until the sweep is done. Words go one at a time; the time per word is
// set by the tree walk over the single-read, single-write tree memory, one
// level per cycle. Request and release walk up from the leaf's parent to the
// root. Allocate first descends from the root to a free leaf, then walks up
// the same way. Allocate on a full pool and the unused operation code finish
// without a walk; a request of a used offset stops after the read of the
// leaf's parent. A result waits in an output register; the next word is
// taken while it waits, and that word's result holds the block until the
// waiting one is taken.

module host_address_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  haa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output haa_pkg::rsp_t rsp
);
	import haa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	haa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	haa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: rtl/haa_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the host address allocator, bound to the top level.
// Depends on haa_pkg and host_address_allocator.

module haa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input haa_pkg::rsp_t rsp
);
	import haa_pkg::*;

	// One word at a time: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("word accepted while another is in flight");

	// Count never exceeds the pool
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.used_count <= COUNT_W'(POOL_SIZE))
		else $error("used count beyond pool size");

	// Full pool means every offset is counted as used
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.used_count == COUNT_W'(POOL_SIZE))
		else $error("pool full reported with free offsets");

	// Failed words grant nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_TAKEN || rsp.status == ST_FULL)
		|-> rsp.granted_address == '0)
		else $error("nonzero address on failure");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

endmodule

bind host_address_allocator haa_checker u_haa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
